>>> rtl/rpw_pkg.sv
// Package for the response pattern waiter: constants, codes, types and helpers.
package rpw_pkg;

	localparam int MAX_PATTERN_BYTES = 20;
	localparam int PIDX_W = $clog2(MAX_PATTERN_BYTES);
	localparam int PLEN_W = 5;
	localparam int TICK_W = 20;
	localparam int ATT_W = 8;
	localparam int MODE_W = 2;
	localparam int STATUS_W = 2;
	localparam int BYTE_W = 8;

	localparam logic [TICK_W-1:0] ELAPSED_MAX = {TICK_W{1'b1}};
	localparam logic [ATT_W-1:0] ATT_MAX = {ATT_W{1'b1}};

	// Item kinds on the request channel.
	localparam logic [MODE_W-1:0] MODE_START = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BYTE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;

	// Phase of the wait, reported as status.
	localparam logic [STATUS_W-1:0] PH_IDLE = 2'd0;
	localparam logic [STATUS_W-1:0] PH_WAIT = 2'd1;
	localparam logic [STATUS_W-1:0] PH_MATCH = 2'd2;
	localparam logic [STATUS_W-1:0] PH_FAIL = 2'd3;

	// Configuration port.
	localparam int APB_AW = 6;
	localparam int APB_DW = 64;
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_PAT_LOW = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PAT_MID = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PAT_HIGH = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_PAT_LEN = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ATT_TICKS = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_MAX_ATT = 3'd5;

	localparam logic [PLEN_W-1:0] RST_PAT_LEN = 5'd4;
	localparam logic [TICK_W-1:0] RST_ATT_TICKS = 20'd1000;
	localparam logic [ATT_W-1:0] RST_MAX_ATT = 8'd5;

	typedef logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0] pat_t;

	typedef struct packed {
		pat_t pattern;
		logic [PLEN_W-1:0] pat_len;
		logic [TICK_W-1:0] attempt_ticks;
		logic [ATT_W-1:0] max_attempts;
	} cfg_t;

	// Window control: shift in a byte, or drop the whole attempt.
	typedef struct packed {
		logic shift;
		logic clear;
		logic [BYTE_W-1:0] rx_byte;
	} win_ctrl_t;

	function automatic logic len_ok(input logic [PLEN_W-1:0] len);
		return (len != '0) && (len <= PLEN_W'(MAX_PATTERN_BYTES));
	endfunction

endpackage

>>> rtl/rpw_if.sv
// Request and response channel interfaces of the response pattern waiter.
interface rpw_req_if;
	logic valid;
	logic ready;
	logic [rpw_pkg::MODE_W-1:0] mode;
	logic [rpw_pkg::BYTE_W-1:0] rx_byte;

	modport source(output valid, mode, rx_byte, input ready);
	modport sink(input valid, mode, rx_byte, output ready);
endinterface

interface rpw_rsp_if;
	logic valid;
	logic ready;
	logic [rpw_pkg::STATUS_W-1:0] status;
	logic [rpw_pkg::ATT_W-1:0] attempt_number;

	modport source(output valid, status, attempt_number, input ready);
	modport sink(input valid, status, attempt_number, output ready);
endinterface

>>> rtl/rpw_cfg.sv
// APB register block holding the pattern, its length and the timeout settings.
module rpw_cfg (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [rpw_pkg::APB_AW-1:0] paddr,
	input logic [rpw_pkg::APB_DW-1:0] pwdata,
	output logic [rpw_pkg::APB_DW-1:0] prdata,
	output logic pready,
	output rpw_pkg::cfg_t cfg
);
	import rpw_pkg::*;

	cfg_t cfg_q;
	logic wr_en;
	logic [REG_IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign idx = paddr[APB_AW-1 -: REG_IDX_W];
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern <= '0;
			cfg_q.pat_len <= RST_PAT_LEN;
			cfg_q.attempt_ticks <= RST_ATT_TICKS;
			cfg_q.max_attempts <= RST_MAX_ATT;
		end else if (wr_en) begin
			case (idx)
				REG_PAT_LOW: cfg_q.pattern[7:0] <= pwdata;
				REG_PAT_MID: cfg_q.pattern[15:8] <= pwdata;
				REG_PAT_HIGH: cfg_q.pattern[19:16] <= pwdata[31:0];
				REG_PAT_LEN: cfg_q.pat_len <= pwdata[PLEN_W-1:0];
				REG_ATT_TICKS: cfg_q.attempt_ticks <= pwdata[TICK_W-1:0];
				REG_MAX_ATT: cfg_q.max_attempts <= pwdata[ATT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_PAT_LOW: prdata = cfg_q.pattern[7:0];
			REG_PAT_MID: prdata = cfg_q.pattern[15:8];
			REG_PAT_HIGH: prdata = {32'd0, cfg_q.pattern[19:16]};
			REG_PAT_LEN: prdata = APB_DW'(cfg_q.pat_len);
			REG_ATT_TICKS: prdata = APB_DW'(cfg_q.attempt_ticks);
			REG_MAX_ATT: prdata = APB_DW'(cfg_q.max_attempts);
			default: prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/rpw_cell.sv
// One window cell: holds one received byte and checks it against its pattern byte.
module rpw_cell (
	input logic clk,
	input logic arst_n,
	input rpw_pkg::win_ctrl_t ctrl,
	input logic [rpw_pkg::BYTE_W-1:0] data_in,
	input logic vld_in,
	input logic [rpw_pkg::BYTE_W-1:0] pat_byte,
	input logic in_use,
	output logic [rpw_pkg::BYTE_W-1:0] data,
	output logic vld,
	output logic hit
);
	import rpw_pkg::*;

	logic [BYTE_W-1:0] data_q;
	logic vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctrl.clear) begin
			vld_q <= 1'b0;
		end else if (ctrl.shift) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			data_q <= data_in;
		end
	end

	// The check looks at what the cell holds after this shift.
	assign hit = !in_use || (vld_in && (data_in == pat_byte));
	assign data = data_q;
	assign vld = vld_q;

endmodule

>>> rtl/rpw_window.sv
// Shifting window of received bytes built as a chain of cells, with the match check.
module rpw_window (
	input logic clk,
	input logic arst_n,
	input rpw_pkg::win_ctrl_t ctrl,
	input rpw_pkg::cfg_t cfg,
	output logic match
);
	import rpw_pkg::*;

	logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0] data;
	logic [MAX_PATTERN_BYTES-1:0] vld;
	logic [MAX_PATTERN_BYTES-1:0] hit;

	for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_cell
		logic [BYTE_W-1:0] data_in;
		logic vld_in;
		logic in_use;
		logic [PLEN_W-1:0] pidx;
		logic [BYTE_W-1:0] pat_byte;

		// Cell j lines up with pattern byte length-1-j, newest byte in cell 0.
		assign in_use = PLEN_W'(j) < cfg.pat_len;
		assign pidx = cfg.pat_len - PLEN_W'(1) - PLEN_W'(j);
		assign pat_byte = (pidx < PLEN_W'(MAX_PATTERN_BYTES)) ?
			cfg.pattern[pidx[PIDX_W-1:0]] : '0;

		if (j == 0) begin : g_head
			assign data_in = ctrl.rx_byte;
			assign vld_in = 1'b1;
		end else begin : g_body
			assign data_in = data[j-1];
			assign vld_in = vld[j-1];
		end

		rpw_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctrl(ctrl),
			.data_in(data_in),
			.vld_in(vld_in),
			.pat_byte(pat_byte),
			.in_use(in_use),
			.data(data[j]),
			.vld(vld[j]),
			.hit(hit[j])
		);
	end

	assign match = len_ok(cfg.pat_len) && (&hit);

endmodule

>>> rtl/response_pattern_waiter.sv
// Top level of the response pattern waiter: wait control, byte window and result buffer.
// Each result is registered in the output register, or in the skid entry on a stall.
// Throughput: one item per cycle while the skid entry is free; starts, bytes and ticks
// update the wait at once, the byte window shifting and all pattern compares in parallel.
// A two-entry output buffer keeps the request side open on a stall until the skid fills.
// Reset (arst_n low) puts the wait in idle, empties the window and loads register defaults.
module response_pattern_waiter (
	input logic clk,
	input logic arst_n,
	rpw_req_if.sink req,
	rpw_rsp_if.source rsp,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [rpw_pkg::APB_AW-1:0] paddr,
	input logic [rpw_pkg::APB_DW-1:0] pwdata,
	output logic [rpw_pkg::APB_DW-1:0] prdata,
	output logic pready
);
	import rpw_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ATT_W-1:0] attempt_number;
	} result_t;

	cfg_t cfg;
	win_ctrl_t win_ctrl;
	logic match;

	// Wait state.
	logic [STATUS_W-1:0] phase_q, phase_d;
	logic [TICK_W-1:0] elapsed_q, elapsed_d, elapsed_inc;
	logic [ATT_W-1:0] attempts_q, attempts_d, attempts_inc;

	// Output register and skid entry.
	logic out_vld_q, skid_vld_q;
	result_t out_q, skid_q, res;
	logic acc, out_fire;

	rpw_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	rpw_window u_window (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(win_ctrl),
		.cfg(cfg),
		.match(match)
	);

	// The request side is open whenever the skid entry is free.
	assign req.ready = !skid_vld_q;
	assign acc = req.valid && req.ready;
	assign out_fire = out_vld_q && rsp.ready;

	// Both counters saturate rather than wrap.
	assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + TICK_W'(1);
	assign attempts_inc = (attempts_q == ATT_MAX) ? attempts_q : attempts_q + ATT_W'(1);

	always_comb begin
		phase_d = phase_q;
		elapsed_d = elapsed_q;
		attempts_d = attempts_q;
		win_ctrl.shift = 1'b0;
		win_ctrl.clear = 1'b0;
		win_ctrl.rx_byte = req.rx_byte;
		if (acc) begin
			case (req.mode)
				MODE_START: begin
					// A start always abandons whatever wait was running.
					win_ctrl.clear = 1'b1;
					elapsed_d = '0;
					attempts_d = '0;
					phase_d = (len_ok(cfg.pat_len) && (cfg.max_attempts != '0)) ?
						PH_WAIT : PH_FAIL;
				end
				MODE_BYTE: begin
					if (phase_q == PH_WAIT) begin
						win_ctrl.shift = 1'b1;
						if (match) begin
							phase_d = PH_MATCH;
						end
					end
				end
				MODE_TICK: begin
					if (phase_q == PH_WAIT) begin
						if (elapsed_inc >= cfg.attempt_ticks) begin
							// Timeout: the attempt is dropped, and a new one begins unless the limit is reached.
							win_ctrl.clear = 1'b1;
							elapsed_d = '0;
							attempts_d = attempts_inc;
							if (attempts_inc >= cfg.max_attempts) begin
								phase_d = PH_FAIL;
							end
						end else begin
							elapsed_d = elapsed_inc;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign res.status = phase_d;
	assign res.attempt_number = attempts_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			elapsed_q <= '0;
			attempts_q <= '0;
		end else begin
			phase_q <= phase_d;
			elapsed_q <= elapsed_d;
			attempts_q <= attempts_d;
		end
	end

	// Result buffer: the output register feeds the port, the skid entry catches
	// one item accepted while the output register is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (out_fire) begin
				skid_vld_q <= 1'b0;
			end
		end else if (acc) begin
			if (out_vld_q && !out_fire) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (out_fire) begin
				out_q <= skid_q;
			end
		end else if (acc) begin
			if (out_vld_q && !out_fire) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.status = out_q.status;
	assign rsp.attempt_number = out_q.attempt_number;

	// The skid entry is only ever filled behind a full output register.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid entry holds an item while the output register is empty");

	// A start leaves the wait either running or failed.
	a_start_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.mode == MODE_START) |=> (phase_q == PH_WAIT || phase_q == PH_FAIL))
		else $error("start did not leave the wait running or failed");

	// A match can only be reached through an accepted byte.
	a_match_by_byte: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(phase_q == PH_MATCH) |-> $past(acc && req.mode == MODE_BYTE))
		else $error("match reported without an accepted byte");

	// Failure comes only from a start or a tick.
	a_fail_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(phase_q == PH_FAIL) |->
			$past(acc && (req.mode == MODE_START || req.mode == MODE_TICK)))
		else $error("failure reported without a start or a tick");

endmodule

>>> tb/response_pattern_waiter_test.sv
// Self-checking testbench for the response pattern waiter: a directed table, then random waits.
module response_pattern_waiter_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rpw_pkg::*;

	// The request channel can carry a fourth mode code, which the block must ignore.
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	// Items to send in total, directed rows and items the block ignores included.
	localparam int ITEM_TARGET = 1900;
	// Items sent under one register setting before the next setting is loaded.
	localparam int SEGMENT_ITEMS = 60;
	// Cycles with no handshake on either channel after which the run is declared hung.
	localparam int QUIET_LIMIT = 5000;
	// Spare cycles at the end catch any stray result.
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ATT_W-1:0] attempts;
	} result_t;

	// A directed row may carry a result typed in by hand; it then replaces the prediction.
	typedef struct packed {
		logic pinned;
		result_t want;
	} pin_t;

	localparam pin_t NO_PIN = '0;

	typedef enum logic {ROW_ITEM, ROW_REG_WRITE} row_kind_e;

	typedef struct {
		row_kind_e kind;
		logic [MODE_W-1:0] mode;
		logic [REG_IDX_W-1:0] reg_idx;
		logic [APB_DW-1:0] data;
		pin_t pin;
	} row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	rpw_req_if req_ch();
	rpw_rsp_if rsp_ch();

	response_pattern_waiter u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Register copy, starting from the reset values.
	logic [63:0] pat_low = '0;
	logic [63:0] pat_mid = '0;
	logic [31:0] pat_high = '0;
	logic [PLEN_W-1:0] pat_len = RST_PAT_LEN;
	logic [TICK_W-1:0] att_ticks = RST_ATT_TICKS;
	logic [ATT_W-1:0] att_limit = RST_MAX_ATT;

	// State of the wait as the testbench tracks it. Entry 0 of the window is the newest byte.
	logic [BYTE_W-1:0] win_bytes [MAX_PATTERN_BYTES];
	int seen_cnt = 0;
	logic [TICK_W-1:0] tick_cnt = '0;
	logic [ATT_W-1:0] timeouts = '0;
	logic [STATUS_W-1:0] phase = PH_IDLE;

	result_t pending_status [$];
	pin_t pin_q [$];
	row_t dir_plan [$];

	int mismatch_cnt = 0;
	int live_items = 0;
	int quiet_cycles = 0;
	int src_idle_pct = 16;
	int snk_idle_pct = 72;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Pattern byte k as the three pattern registers hold it; nothing beyond the last one.
	function automatic logic [BYTE_W-1:0] pattern_byte(input int k);
		if (k < 8) begin
			return pat_low[8*k +: 8];
		end else if (k < 16) begin
			return pat_mid[8*(k-8) +: 8];
		end else if (k < MAX_PATTERN_BYTES) begin
			return pat_high[8*(k-16) +: 8];
		end
		return '0;
	endfunction

	function automatic void apply_reg(input logic [REG_IDX_W-1:0] idx,
			input logic [APB_DW-1:0] value);
		case (idx)
			REG_PAT_LOW: pat_low = value;
			REG_PAT_MID: pat_mid = value;
			REG_PAT_HIGH: pat_high = value[31:0];
			REG_PAT_LEN: pat_len = value[PLEN_W-1:0];
			REG_ATT_TICKS: att_ticks = value[TICK_W-1:0];
			REG_MAX_ATT: att_limit = value[ATT_W-1:0];
			default: ;
		endcase
	endfunction

	// A timeout or a new start drops everything the current attempt has collected.
	function automatic void drop_attempt();
		foreach (win_bytes[j]) win_bytes[j] = '0;
		seen_cnt = 0;
		tick_cnt = '0;
	endfunction

	// Advances the tracked wait by one accepted item and returns the status it reports.
	function automatic result_t advance_waiter(input logic [MODE_W-1:0] mode,
			input logic [BYTE_W-1:0] rx);
		result_t res;
		logic len_valid;
		logic hit;
		len_valid = (pat_len >= 1) && (pat_len <= MAX_PATTERN_BYTES);
		if (mode == MODE_START) begin
			// A start always begins afresh, even in the middle of a wait.
			drop_attempt();
			timeouts = '0;
			phase = (len_valid && att_limit != 0) ? PH_WAIT : PH_FAIL;
		end else if (phase == PH_WAIT && mode == MODE_BYTE) begin
			for (int j = MAX_PATTERN_BYTES - 1; j > 0; j--) win_bytes[j] = win_bytes[j-1];
			win_bytes[0] = rx;
			if (seen_cnt < MAX_PATTERN_BYTES) seen_cnt++;
			// The newest byte must equal the last pattern byte, and so on backwards.
			hit = len_valid && (seen_cnt >= pat_len);
			for (int j = 0; j < pat_len && j < MAX_PATTERN_BYTES; j++) begin
				if (win_bytes[j] != pattern_byte(pat_len - 1 - j)) hit = 1'b0;
			end
			if (hit) phase = PH_MATCH;
		end else if (phase == PH_WAIT && mode == MODE_TICK) begin
			if (tick_cnt != ELAPSED_MAX) tick_cnt++;
			if (tick_cnt >= att_ticks) begin
				drop_attempt();
				if (timeouts != ATT_MAX) timeouts++;
				if (timeouts >= att_limit) phase = PH_FAIL;
			end
		end
		res.status = phase;
		res.attempts = timeouts;
		return res;
	endfunction

	function automatic void add_item(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] rx);
		row_t r;
		r.kind = ROW_ITEM;
		r.mode = mode;
		r.reg_idx = '0;
		r.data = APB_DW'(rx);
		r.pin = NO_PIN;
		dir_plan.push_back(r);
	endfunction

	function automatic void add_check(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] rx,
			input logic [STATUS_W-1:0] status, input logic [ATT_W-1:0] attempts);
		row_t r;
		r.kind = ROW_ITEM;
		r.mode = mode;
		r.reg_idx = '0;
		r.data = APB_DW'(rx);
		r.pin.pinned = 1'b1;
		r.pin.want.status = status;
		r.pin.want.attempts = attempts;
		dir_plan.push_back(r);
	endfunction

	function automatic void add_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
		row_t r;
		r.kind = ROW_REG_WRITE;
		r.mode = MODE_START;
		r.reg_idx = idx;
		r.data = value;
		r.pin = NO_PIN;
		dir_plan.push_back(r);
	endfunction

	task automatic flag_error(input string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, msg);
	endtask

	// Offers one item, starting at a falling edge, after a random number of idle cycles.
	// Returns at the falling edge after acceptance with valid still high, so that the next
	// call either keeps it high or lowers it, never both in one step.
	task automatic send_item(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] rx,
			input pin_t pin);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pin_q.push_back(pin);
		req_ch.valid <= 1'b1;
		req_ch.mode <= mode;
		req_ch.rx_byte <= rx;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	// Stops offering items and waits at falling edges until every result is back. Every item
	// yields a result, so an empty queue means the block holds nothing more.
	task automatic settle();
		req_ch.valid <= 1'b0;
		while (pending_status.size() != 0) @(negedge clk);
	endtask

	// Setup cycle, then access cycle; the register takes the value at the access edge. An idle
	// gap with psel low keeps back-to-back writes from touching psel twice in a step.
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		apply_reg(idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// The receiver stalls at random, with a fresh choice at every falling edge.
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
	end

	// Scoreboard and watchdog. Results are checked before the new item is predicted, so the
	// order of the two handshakes within one edge never matters.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		result_t model;
		pin_t pin;
		logic progress;
		if (arst_n) begin
			progress = 1'b0;
			if (rsp_ch.valid && rsp_ch.ready) begin
				progress = 1'b1;
				got.status = rsp_ch.status;
				got.attempts = rsp_ch.attempt_number;
				if (pending_status.size() == 0) begin
					flag_error($sformatf("unexpected item: status %0d, attempt_number %0d",
						got.status, got.attempts));
				end else begin
					want = pending_status.pop_front();
					if (got.status !== want.status) begin
						flag_error($sformatf("status: expected %0d, got %0d",
							want.status, got.status));
					end
					if (got.attempts !== want.attempts) begin
						flag_error($sformatf("attempt_number: expected %0d, got %0d",
							want.attempts, got.attempts));
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				progress = 1'b1;
				pin = (pin_q.size() != 0) ? pin_q.pop_front() : NO_PIN;
				// Every accepted item counts, including those the block ignores.
				live_items++;
				model = advance_waiter(req_ch.mode, req_ch.rx_byte);
				pending_status.push_back(pin.pinned ? pin.want : model);
			end
			quiet_cycles = progress ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[response_pattern_waiter] ERROR");
				$finish;
			end
		end
	end

	initial begin
		logic [8*MAX_PATTERN_BYTES-1:0] new_pat;
		logic [BYTE_W-1:0] b;
		int seg_start;
		int style;
		int pick;
		int span;
		int bad;
		int n;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.mode = MODE_START;
		req_ch.rx_byte = '0;
		rsp_ch.ready = 1'b0;
		foreach (win_bytes[j]) win_bytes[j] = '0;

		// Out of reset the pattern is four zero bytes. Nothing runs yet, so bytes, ticks and
		// the unused mode all report idle.
		add_check(MODE_BYTE, 8'hFF, PH_IDLE, 8'd0);
		add_check(MODE_TICK, 8'h00, PH_IDLE, 8'd0);
		add_check(MODE_UNUSED, 8'hA5, PH_IDLE, 8'd0);
		add_check(MODE_START, 8'h00, PH_WAIT, 8'd0);
		add_check(MODE_BYTE, 8'h00, PH_WAIT, 8'd0);
		add_check(MODE_BYTE, 8'h00, PH_WAIT, 8'd0);
		add_check(MODE_BYTE, 8'h00, PH_WAIT, 8'd0);
		add_check(MODE_BYTE, 8'h00, PH_MATCH, 8'd0);
		// With no attempts allowed a start fails at once.
		add_reg(REG_MAX_ATT, 64'd0);
		add_check(MODE_START, 8'hFF, PH_FAIL, 8'd0);
		// Longest pattern, most attempts, and a zero attempt length: each tick times out.
		add_reg(REG_MAX_ATT, 64'd255);
		add_reg(REG_ATT_TICKS, 64'd0);
		add_reg(REG_PAT_LEN, 64'd20);
		add_reg(REG_PAT_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
		add_reg(REG_PAT_MID, 64'h0123_4567_89AB_CDEF);
		add_reg(REG_PAT_HIGH, 64'hFFFF_FFFF);
		add_check(MODE_START, 8'h00, PH_WAIT, 8'd0);
		add_check(MODE_TICK, 8'h00, PH_WAIT, 8'd1);
		add_check(MODE_TICK, 8'hFF, PH_WAIT, 8'd2);
		add_item(MODE_BYTE, 8'hFF);
		// A zero length written during a wait means no byte can match; a start then fails,
		// as it does for a length above the maximum.
		add_reg(REG_PAT_LEN, 64'd0);
		add_check(MODE_BYTE, 8'hFF, PH_WAIT, 8'd2);
		add_check(MODE_START, 8'h00, PH_FAIL, 8'd0);
		add_reg(REG_PAT_LEN, 64'd21);
		add_check(MODE_START, 8'h00, PH_FAIL, 8'd0);
		// One-byte pattern with the longest attempt; restarts while busy and after a match.
		add_reg(REG_PAT_LEN, 64'd1);
		add_reg(REG_PAT_LOW, 64'hFF);
		add_reg(REG_ATT_TICKS, 64'hF_FFFF);
		add_reg(REG_MAX_ATT, 64'd1);
		add_check(MODE_START, 8'h00, PH_WAIT, 8'd0);
		add_check(MODE_TICK, 8'h00, PH_WAIT, 8'd0);
		add_check(MODE_BYTE, 8'h00, PH_WAIT, 8'd0);
		add_check(MODE_BYTE, 8'hFF, PH_MATCH, 8'd0);
		add_check(MODE_TICK, 8'h00, PH_MATCH, 8'd0);
		add_check(MODE_START, 8'h00, PH_WAIT, 8'd0);
		add_check(MODE_START, 8'h00, PH_WAIT, 8'd0);
		// A one-tick attempt with one attempt allowed: the first tick ends the wait.
		add_reg(REG_ATT_TICKS, 64'd1);
		add_check(MODE_TICK, 8'h00, PH_FAIL, 8'd1);
		add_check(MODE_BYTE, 8'hFF, PH_FAIL, 8'd1);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_plan[i]) begin
			if (dir_plan[i].kind == ROW_REG_WRITE) begin
				settle();
				write_reg(dir_plan[i].reg_idx, dir_plan[i].data);
			end else begin
				send_item(dir_plan[i].mode, dir_plan[i].data[BYTE_W-1:0], dir_plan[i].pin);
			end
		end

		// Random part: segments of waits, each under a freshly drawn register setting. The
		// wait is left running across a setting change on purpose.
		while (live_items < ITEM_TARGET) begin
			// Sender gaps with heavy receiver stalls first, then the reverse, then full rate.
			if (live_items >= 2 * ITEM_TARGET / 3) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end else if (live_items >= ITEM_TARGET / 3) begin
				src_idle_pct = 72;
				snk_idle_pct = 16;
			end
			settle();

			// Patterns are sometimes uniform or drawn from two letters, which makes partial
			// and overlapping matches common.
			style = $urandom_range(0, 7);
			for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
				case (style)
					0: b = 8'hFF;
					1: b = 8'h00;
					2, 3: b = $urandom_range(0, 1) ? 8'h41 : 8'h42;
					default: b = BYTE_W'($urandom);
				endcase
				new_pat[8*k +: 8] = b;
			end
			write_reg(REG_PAT_LOW, new_pat[63:0]);
			write_reg(REG_PAT_MID, new_pat[127:64]);
			write_reg(REG_PAT_HIGH, APB_DW'(new_pat[159:128]));

			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				n = $urandom_range(1, 6);
			end else if (pick < 85) begin
				n = $urandom_range(7, 19);
			end else if (pick < 90) begin
				n = MAX_PATTERN_BYTES;
			end else begin
				n = $urandom_range(0, 1) ? 0 : $urandom_range(21, 31);
			end
			write_reg(REG_PAT_LEN, APB_DW'(n));

			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				n = $urandom_range(1, 20);
			end else if (pick < 75) begin
				n = 0;
			end else if (pick < 90) begin
				n = $urandom_range(21, 200);
			end else begin
				n = 20'hF_FFFF;
			end
			write_reg(REG_ATT_TICKS, APB_DW'(n));

			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				n = $urandom_range(1, 6);
			end else if (pick < 80) begin
				n = 0;
			end else if (pick < 90) begin
				n = 255;
			end else begin
				n = $urandom_range(7, 20);
			end
			write_reg(REG_MAX_ATT, APB_DW'(n));

			// Bytes that can be sent as the pattern, even when the length is out of range.
			span = (pat_len == 0) ? 1 : ((pat_len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : pat_len);

			seg_start = live_items;
			while (live_items - seg_start < SEGMENT_ITEMS) begin
				send_item(MODE_START, BYTE_W'($urandom), NO_PIN);
				repeat ($urandom_range(1, 4)) begin
					pick = $urandom_range(0, 99);
					if (pick < 45) begin
						// The pattern in order, sometimes after a partial prefix of itself.
						// A quarter of the time one byte is inverted, so the match fails there.
						if ($urandom_range(0, 2) == 0) begin
							n = $urandom_range(1, span);
							for (int k = 0; k < n; k++) send_item(MODE_BYTE, pattern_byte(k), NO_PIN);
						end
						bad = ($urandom_range(0, 3) == 0) ? $urandom_range(0, span - 1) : -1;
						for (int k = 0; k < span; k++) begin
							send_item(MODE_BYTE, (k == bad) ? ~pattern_byte(k) : pattern_byte(k),
								NO_PIN);
						end
					end else if (pick < 65) begin
						repeat ($urandom_range(1, 8)) begin
							send_item(MODE_BYTE, pattern_byte($urandom_range(0, span - 1)), NO_PIN);
						end
					end else if (pick < 80) begin
						// Up to enough ticks to reach and pass one timeout when attempts are short.
						n = (att_ticks < 38) ? int'(att_ticks) + 2 : 40;
						repeat ($urandom_range(1, n)) send_item(MODE_TICK, BYTE_W'($urandom), NO_PIN);
					end else if (pick < 83) begin
						// A long run of ticks, so that many attempts can run out in one wait.
						repeat (260) send_item(MODE_TICK, BYTE_W'($urandom), NO_PIN);
					end else begin
						repeat ($urandom_range(1, 4)) begin
							send_item(MODE_W'($urandom_range(0, 3)), BYTE_W'($urandom), NO_PIN);
						end
					end
				end
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("[response_pattern_waiter] OK");
		end else begin
			$display("[response_pattern_waiter] ERROR");
		end
		$finish;
	end

endmodule
